[sv/gb5_pkg.sv]
// Shared types and constants for the 5x5 RGBA blur block.
// No dependencies; imported by the top level.
package gb5_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // Result queue depth and pointer width
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  // Configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam int CFG_DW = 13;

  // Input word opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_last;
  } out_word_t;

  // Border masks of the 5x5 window: column j, row k valid
  typedef struct packed {
    logic [4:0] col;
    logic [4:0] row;
  } tap_mask_t;

  // Binomial tap weight 1 4 6 4 1
  function automatic logic [2:0] tap_wt(input int k);
    logic [2:0] w;
    case (k)
      0, 4:    w = 3'd1;
      1, 3:    w = 3'd4;
      default: w = 3'd6;
    endcase
    return w;
  endfunction

endpackage

[sv/gaussian_blur_5x5_rgba_top.sv]
// 5x5 binomial blur on an RGBA raster stream; line store in gb5_ram.
// Depends on gb5_pkg and gb5_ram.
// Throughput: one word per cycle when not stalled; a result passes through the
// line-store read, window shift, column sums and row sum into the result queue.
// After the last pixel of a frame smaller than 2*W+2 pixels, input stalls
// while the window is advanced over the missing positions.
// Input also stalls while queued plus in-flight results fill the 8-word queue.
// Reset: counters cleared, width and height 1024; line store is not cleared.
module gaussian_blur_5x5_rgba_top
  import gb5_pkg::*;
#(
  parameter int MaxWidth  = MAX_WIDTH,
  parameter int MaxHeight = MAX_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  localparam int AW = $clog2(MaxWidth);
  localparam int CW = $clog2(MaxWidth + 2);
  localparam int RW = $clog2(MaxHeight + 4);
  localparam int DW = $clog2(2 * MaxWidth + 3);

  // Configuration
  logic [10:0] width_q;
  logic [12:0] height_q;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 13'd1024;
    end else if (cfg_we) begin
      if (cfg_index_i == CFG_WIDTH) begin
        width_q <= cfg_data_i[10:0];
      end else begin
        height_q <= cfg_data_i;
      end
    end
  end

  // Clamp the frame size
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  always_comb begin
    if (width_q < 11'd5) begin
      w_eff = CW'(5);
    end else if (32'(width_q) > MaxWidth) begin
      w_eff = CW'(MaxWidth);
    end else begin
      w_eff = CW'(width_q);
    end
    if (height_q == 13'd0) begin
      h_eff = RW'(1);
    end else if (32'(height_q) > MaxHeight) begin
      h_eff = RW'(MaxHeight);
    end else begin
      h_eff = RW'(height_q);
    end
  end

  // Position counters and lead of input over output
  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [DW-1:0] lead_q, lead_d, lead_tgt;

  logic input_done, pad_act, space_ok, acc, pix_go, flush_go, step, emit, last;
  logic [1:0]         inflight;
  logic [FIFO_AW:0]   fifo_cnt_q, fifo_cnt_d;
  logic               s1_emit_q, s2_emit_q, s3_emit_q;

  assign lead_tgt   = DW'({w_eff, 1'b0}) + DW'(2);
  assign input_done = in_row_q >= h_eff;
  assign pad_act    = input_done && (lead_q < lead_tgt);
  assign inflight   = 2'({1'b0, s1_emit_q}) + 2'({1'b0, s2_emit_q}) + 2'({1'b0, s3_emit_q});
  assign space_ok   = ((FIFO_AW + 2)'(fifo_cnt_q) + (FIFO_AW + 2)'(inflight))
                      < (FIFO_AW + 2)'(FIFO_DEPTH);
  assign in_ready_o = !pad_act && space_ok;
  assign acc        = in_valid_i && in_ready_o;
  assign pix_go     = acc && (in_data_i.opcode == OP_PIXEL) && !input_done;
  assign flush_go   = acc && (in_data_i.opcode == OP_FLUSH) && input_done;
  assign step       = pix_go || flush_go || pad_act;
  assign emit       = flush_go || (pix_go && (lead_q == lead_tgt));
  assign last       = (out_row_q == h_eff - RW'(1)) && (out_col_q == w_eff - CW'(1));

  // Advance counters; restart on a configuration write or at frame end
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    lead_d    = lead_q;
    if (cfg_we || (emit && last)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      lead_d    = '0;
    end else if (step) begin
      if (in_col_q == w_eff - CW'(1)) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
      if (emit) begin
        if (out_col_q == w_eff - CW'(1)) begin
          out_col_d = '0;
          out_row_d = out_row_q + RW'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end else begin
        lead_d = lead_q + DW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lead_q    <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lead_q    <= lead_d;
    end
  end

  // Border masks for the output position
  tap_mask_t mask0;
  always_comb begin
    mask0.col[0] = out_col_q >= CW'(2);
    mask0.col[1] = out_col_q >= CW'(1);
    mask0.col[2] = 1'b1;
    mask0.col[3] = (out_col_q + CW'(1)) < w_eff;
    mask0.col[4] = (out_col_q + CW'(2)) < w_eff;
    mask0.row[0] = out_row_q >= RW'(2);
    mask0.row[1] = out_row_q >= RW'(1);
    mask0.row[2] = 1'b1;
    mask0.row[3] = (out_row_q + RW'(1)) < h_eff;
    mask0.row[4] = (out_row_q + RW'(2)) < h_eff;
  end

  // Stage 1: line-store read data arrives
  logic            s1_vld_q, s1_last_q;
  tap_mask_t       s1_mask_q;
  logic [AW-1:0]   s1_addr_q;
  logic [31:0]     s1_pix_q;
  logic [127:0]    ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_emit_q <= 1'b0;
    end else begin
      s1_vld_q  <= step;
      s1_emit_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= last;
    s1_mask_q <= mask0;
    s1_addr_q <= in_col_q[AW-1:0];
    s1_pix_q  <= {in_data_i.alpha_in, in_data_i.blue_in,
                  in_data_i.green_in, in_data_i.red_in};
  end

  // Four previous rows per column, newest in the low word
  gb5_ram #(
    .Width (128),
    .Depth (MaxWidth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q),
    .waddr_i (s1_addr_q),
    .wdata_i ({ram_rdata[95:0], s1_pix_q}),
    .raddr_i (in_col_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Shift the window one column, oldest row at index 0
  logic [31:0] win_q [5][5];
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 5; k++) begin
          win_q[j][k] <= win_q[j+1][k];
        end
      end
      win_q[4][0] <= ram_rdata[127:96];
      win_q[4][1] <= ram_rdata[95:64];
      win_q[4][2] <= ram_rdata[63:32];
      win_q[4][3] <= ram_rdata[31:0];
      win_q[4][4] <= s1_pix_q;
    end
  end

  // Stage 2: weighted column sums
  logic      s2_last_q;
  tap_mask_t s2_mask_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_emit_q <= 1'b0;
    end else begin
      s2_emit_q <= s1_vld_q && s1_emit_q;
    end
  end
  always_ff @(posedge clk_i) begin
    s2_last_q <= s1_last_q;
    s2_mask_q <= s1_mask_q;
  end

  logic [11:0] cs_d [5][4];
  logic [11:0] cs_q [5][4];
  always_comb begin
    for (int j = 0; j < 5; j++) begin
      for (int c = 0; c < 4; c++) begin
        cs_d[j][c] = '0;
        for (int k = 0; k < 5; k++) begin
          if (s2_mask_q.col[j] && s2_mask_q.row[k]) begin
            cs_d[j][c] = cs_d[j][c] + 12'(tap_wt(k) * win_q[j][k][8*c +: 8]);
          end
        end
      end
    end
  end

  // Stage 3: horizontal sum
  logic s3_last_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_emit_q <= 1'b0;
    end else begin
      s3_emit_q <= s2_emit_q;
    end
  end
  always_ff @(posedge clk_i) begin
    s3_last_q <= s2_last_q;
    cs_q      <= cs_d;
  end

  logic [15:0] tot [4];
  out_word_t   res;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      tot[c] = '0;
      for (int j = 0; j < 5; j++) begin
        tot[c] = tot[c] + 16'(tap_wt(j) * cs_q[j][c]);
      end
    end
    res.red_out    = tot[0][15:8];
    res.green_out  = tot[1][15:8];
    res.blue_out   = tot[2][15:8];
    res.alpha_out  = tot[3][15:8];
    res.frame_last = s3_last_q;
  end

  // Result queue
  out_word_t          fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic               pop;

  assign out_valid_o = fifo_cnt_q != '0;
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    fifo_cnt_d = fifo_cnt_q;
    if (s3_emit_q && !pop) begin
      fifo_cnt_d = fifo_cnt_q + (FIFO_AW + 1)'(1);
    end else if (!s3_emit_q && pop) begin
      fifo_cnt_d = fifo_cnt_q - (FIFO_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      fifo_cnt_q <= fifo_cnt_d;
      if (s3_emit_q) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_emit_q) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

endmodule

[sv/gb5_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gb5_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write, and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
